// File: src/bmsf_pkg.sv
// shared constants and types for the binary mask speckle filter
// no dependencies; compile first
package bmsf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);       // input/output column
    localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;  // input row, runs past the frame on drain
    localparam int OROW_W = $clog2(MAX_HEIGHT);      // output row
    localparam int FW_W   = 11;                      // frame_width register
    localparam int FH_W   = 13;                      // frame_height register
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;
    localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FH_MAX   = FH_W'(MAX_HEIGHT);

    // line store word: bit 1 = row above, bit 0 = middle row
    typedef logic [1:0] line_word_t;
    typedef logic [8:0] window_t;

endpackage

// File: src/bmsf_if.sv
// stream channel interfaces for the speckle filter
// depends on nothing; compile after bmsf_pkg
interface bmsf_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic mask_bit;

    modport source (output valid, output kind, output mask_bit, input ready);
    modport sink (input valid, input kind, input mask_bit, output ready);
endinterface

interface bmsf_out_if;
    logic valid;
    logic ready;
    logic cleaned_bit;
    logic frame_end;

    modport source (output valid, output cleaned_bit, output frame_end, input ready);
    modport sink (input valid, input cleaned_bit, input frame_end, output ready);
endinterface

// File: src/binary_mask_speckle_filter.sv
// top level of the binary mask speckle filter (3x3 isolated pixel removal)
// depends on bmsf_pkg, bmsf_if and bmsf_ram
//
// usage
//   mask_in  : one item per pixel (kind = pixel) in raster order, then drain
//              items (kind = drain) that flush the pending results
//   mask_out : one cleaned pixel per result item, frame_end on the last one
//   cfg_*    : frame_width (index 0) and frame_height (index 1), written only
//              while idle; any write restarts the frame
// timing
//   an item is registered into the input stage on acceptance, together with the
//   line store read of its column, and its result is then registered into the
//   output register
//   one item per cycle sustained while mask_out is not held off, set by the
//   single line store access per pixel; the first drain item of a one-row
//   frame takes two window steps
//   results lag pixels by frame_width + 1 items
// reset
//   counters and the window clear, dimensions go to 640 x 480; the line store
//   is not cleared, its reads are gated by row
// stall
//   when mask_out is held off, one more item is taken into the input stage
//   and then mask_in.ready drops until the output register empties
module binary_mask_speckle_filter (
    input  logic                            clk,
    input  logic                            rst_n,
    bmsf_in_if.sink                         mask_in,
    bmsf_out_if.source                      mask_out,
    input  logic                            cfg_we,
    input  logic [bmsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmsf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bmsf_pkg::*;

    // dimension registers
    logic [FW_W-1:0]   fw_reg, fw_next;
    logic [FH_W-1:0]   fh_reg, fh_next;

    // raster position of the next window step to issue, and of the next result
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;

    // second window step still owed by a one-row drain item
    logic              pend_reg, pend_next;

    // input stage: one issued window step waiting for its line store word
    logic              a_valid_reg, a_valid_next;
    logic [COL_W-1:0]  a_col_reg;
    logic              a_bit_reg;
    logic              a_top_en_reg;
    logic              a_mid_en_reg;
    logic              a_emit_reg;
    logic              a_last_reg;

    // write-to-read forwarding for the line store
    logic              fwd_reg, fwd_next;
    line_word_t        fwd_data_reg;

    window_t           window_reg, window_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              out_bit_reg;
    logic              out_end_reg;

    // line store
    logic [COL_W-1:0]  ram_raddr;
    line_word_t        ram_rdata;
    line_word_t        ram_wdata;
    line_word_t        line_word;

    // control
    logic              complete;
    logic              take;
    logic              a_advance;
    logic              a_free;
    logic              in_push;
    logic              issue;
    logic              issue_bit;
    logic              issue_emit;
    logic              issue_last;
    logic              issue_double;
    logic              in_col_wrap;

    // datapath of the step in the input stage
    logic              top_b;
    logic              mid_b;
    logic [2:0]        col_bits;
    window_t           eval_bits;
    window_t           window_step;
    logic              cleaned;

    // ---------------------------------------------------------------- handshake
    assign a_advance = a_valid_reg && (!a_emit_reg || !out_valid_reg || mask_out.ready);
    assign a_free    = !a_valid_reg || a_advance;
    assign mask_in.ready = !pend_reg && a_free;
    assign take      = mask_in.valid && mask_in.ready;

    // all rows of the frame have gone in
    assign complete  = in_row_reg >= ROW_W'(fh_reg);

    // pixels after the frame is in and drain items before it is in are dropped
    assign in_push = take && (((mask_in.kind == KIND_PIXEL) && !complete) ||
                              ((mask_in.kind == KIND_DRAIN) && complete));
    // one-row frame: the first drain item needs two window steps
    assign issue_double = in_push && (mask_in.kind == KIND_DRAIN) &&
                          (in_row_reg == ROW_W'(1)) && (in_col_reg == '0);
    assign issue     = in_push || (pend_reg && a_free);
    assign issue_bit = !pend_reg && (mask_in.kind == KIND_PIXEL) && mask_in.mask_bit;

    assign issue_emit = (in_row_reg > ROW_W'(1)) ||
                        ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
    assign issue_last = issue_emit &&
                        (({1'b0, out_row_reg} + FH_W'(1)) >= fh_reg) &&
                        (({1'b0, out_col_reg} + FW_W'(1)) >= fw_reg);
    assign in_col_wrap = ({1'b0, in_col_reg} + FW_W'(1)) >= fw_reg;

    // ---------------------------------------------------------------- line store
    // while the input stage is stalled it re-reads its own column
    assign ram_raddr = (a_valid_reg && !a_advance) ? a_col_reg : in_col_reg;
    assign line_word = fwd_reg ? fwd_data_reg : ram_rdata;

    bmsf_ram #(
        .WIDTH ($bits(line_word_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (a_advance),
        .waddr (a_col_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- window step
    always_comb
    begin
        top_b    = a_top_en_reg && line_word[1];
        mid_b    = a_mid_en_reg && line_word[0];
        col_bits = {a_bit_reg, mid_b, top_b};
        if (a_col_reg == '0)
        begin
            // centre is the last column of the previous row, right column off frame
            eval_bits   = {3'b000, window_reg[8:3]};
            window_step = {col_bits, 6'b000000};
        end
        else
        begin
            window_step = {col_bits, window_reg[8:3]};
            eval_bits   = window_step;
        end
        // keep a set centre only with two or more set neighbours
        cleaned   = eval_bits[4] && ($countones(eval_bits & 9'h1EF) >= 2);
        ram_wdata = {mid_b, a_bit_reg};
    end

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        window_next  = window_reg;

        if (a_advance)
        begin
            window_next = a_last_reg ? '0 : window_step;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    if (cfg_data[FW_W-1:0] == '0)
                        fw_next = FW_W'(1);
                    else if (cfg_data[FW_W-1:0] > FW_MAX)
                        fw_next = FW_MAX;
                    else
                        fw_next = cfg_data[FW_W-1:0];
                end
                REG_FRAME_HEIGHT:
                begin
                    if (cfg_data[FH_W-1:0] == '0)
                        fh_next = FH_W'(1);
                    else if (cfg_data[FH_W-1:0] > FH_MAX)
                        fh_next = FH_MAX;
                    else
                        fh_next = cfg_data[FH_W-1:0];
                end
                default:
                begin
                    fw_next = fw_reg;
                end
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pend_next    = 1'b0;
            window_next  = '0;
        end
        else if (issue)
        begin
            pend_next = issue_double;
            if (issue_last)
            begin
                // last result of the frame: back to the start
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else
            begin
                if (in_col_wrap)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                if (issue_emit)
                begin
                    if (({1'b0, out_col_reg} + FW_W'(1)) >= fw_reg)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + OROW_W'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
        end

        a_valid_next = issue ? 1'b1 : (a_advance ? 1'b0 : a_valid_reg);
        // the read issued this cycle misses the write made at this edge
        fwd_next = issue && a_advance && (a_col_reg == in_col_reg);

        if (a_advance && a_emit_reg)
            out_valid_next = 1'b1;
        else if (mask_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg        <= FW_RESET;
            fh_reg        <= FH_RESET;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            pend_reg      <= 1'b0;
            a_valid_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            pend_reg      <= pend_next;
            a_valid_reg   <= a_valid_next;
            fwd_reg       <= fwd_next;
            window_reg    <= window_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            a_col_reg    <= in_col_reg;
            a_bit_reg    <= issue_bit;
            a_top_en_reg <= in_row_reg >= ROW_W'(2);
            a_mid_en_reg <= in_row_reg >= ROW_W'(1);
            a_emit_reg   <= issue_emit;
            a_last_reg   <= issue_last;
        end
        fwd_data_reg <= ram_wdata;
        if (a_advance && a_emit_reg)
        begin
            out_bit_reg <= cleaned;
            out_end_reg <= a_last_reg;
        end
    end

    assign mask_out.valid       = out_valid_reg;
    assign mask_out.cleaned_bit = out_bit_reg;
    assign mask_out.frame_end   = out_end_reg;

    // ---------------------------------------------------------------- checks
    // the owed second window step blocks new items
    a_pend_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !mask_in.ready)
        else $error("input accepted while a drain step is owed");

    // forwarding only applies to a step held in the input stage
    a_fwd_staged: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> a_valid_reg)
        else $error("forward flag without a staged step");

    // issuing the last result restarts the raster position
    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && issue_last && !cfg_we) |=> (in_row_reg == '0 && in_col_reg == '0))
        else $error("frame did not restart after its last result");

    // a result only leaves the input stage when the output register can take it
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (a_advance && a_emit_reg && out_valid_reg) |-> mask_out.ready)
        else $error("output register overrun");

endmodule

// File: src/bmsf_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module bmsf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
